[rtl/core/epm_pkg.sv]
// Shared types and constants for the exact pattern matcher.
package epm_pkg;

    localparam int PAT_BYTES  = 16;  // pattern bytes held in the registers
    localparam int PAT_IDX_W  = 4;   // index into the pattern bytes
    localparam int LEN_W      = 5;
    localparam int POS_W      = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 2;

    // register index, paddr[4:3]
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NO_OVLP  = 2'd3;

    typedef logic [PAT_BYTES-1:0][7:0] pat_vec_t;

    // control handed to every cell of the window chain
    typedef struct packed {
        logic             shift;    // a text byte is accepted
        logic             clear;    // the accepted byte closes the text
        logic [LEN_W-1:0] len;
        pat_vec_t         pattern;
    } cell_ctl_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             done;
        logic [POS_W-1:0] count;
    } result_t;

endpackage

[rtl/core/epm_cell.sv]
// Window cell: holds a text byte, compares the byte from its neighbor or the input.
module epm_cell
    import epm_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  logic [7:0] din,
    input  logic       vin,
    output logic [7:0] dout,
    output logic       vout,
    output logic       eq
);

    localparam logic [LEN_W-1:0] IDX_L = LEN_W'(IDX);

    logic [7:0]           byte_reg;
    logic                 valid_reg;
    logic                 active;
    logic [LEN_W-1:0]     pidx_full;
    logic [PAT_IDX_W-1:0] pidx;

    // this cell checks pattern byte len-1-IDX against the byte that lands here
    assign active    = ctl.len > IDX_L;
    assign pidx_full = ctl.len - IDX_L - LEN_W'(1);
    assign pidx      = pidx_full[PAT_IDX_W-1:0];
    assign eq        = !active || (vin && (din == ctl.pattern[pidx]));

    assign dout = byte_reg;
    assign vout = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_reg <= ctl.clear ? 1'b0 : vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            byte_reg <= din;
        end
    end

endmodule

[rtl/core/exact_pattern_match_all_occurrences_core.sv]
// Top level of the exact pattern matcher: window cell chain, counters, output buffer, APB.
//
//  channel  dir  handshake        payload
//  s_*      in   tvalid/tready    tdata = text_byte, tlast = last_byte
//  m_*      out  tvalid/tready    tdata = match_position, match_count; tlast = text_done;
//                                 tuser = match_found
//  APB      in   psel/penable     pwdata = register value, pready always high
//
// One text byte per cycle while s_tready is high: window compare, start-offset compare
// and count update finish in the accept cycle and land in the output register or skid.
// A two-entry output buffer (output register plus skid) lets the input run on while a
// result waits; s_tready drops only while both entries are full.
// Reset clears window valid bits, position, count and registers; no clearing pass.
// The last byte of a text clears position, count and window in the same transfer.
module exact_pattern_match_all_occurrences_core
    import epm_pkg::*;
#(
    parameter int PAT_MAX = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // text in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    input  logic                  s_tlast,
    // results out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // [31:0] match_position, [63:32] match_count
    output logic                  m_tlast,
    output logic                  m_tuser,   // [0] match_found
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int NCELL = (PAT_MAX < PAT_BYTES) ? PAT_MAX : PAT_BYTES;

    // configuration registers
    logic [63:0]      pat_low_reg;
    logic [63:0]      pat_high_reg;
    logic [LEN_W-1:0] pat_len_reg;
    logic             no_ovlp_reg;

    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            no_ovlp_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_PAT_LOW:  pat_low_reg  <= pwdata;
                REG_PAT_HIGH: pat_high_reg <= pwdata;
                REG_PAT_LEN:  pat_len_reg  <= pwdata[LEN_W-1:0];
                REG_NO_OVLP:  no_ovlp_reg  <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PAT_LOW:  prdata = pat_low_reg;
            REG_PAT_HIGH: prdata = pat_high_reg;
            REG_PAT_LEN:  prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, pat_len_reg};
            REG_NO_OVLP:  prdata = {{(CFG_DATA_W-1){1'b0}}, no_ovlp_reg};
            default:      prdata = '0;
        endcase
    end

    // window cell chain
    logic      accept;
    cell_ctl_t ctl;
    logic [7:0] chain_d [NCELL+1];
    logic       chain_v [NCELL+1];
    logic [NCELL-1:0] cell_eq;

    assign accept = s_tvalid && s_tready;

    assign ctl.shift   = accept;
    assign ctl.clear   = s_tlast;
    assign ctl.len     = pat_len_reg;
    assign ctl.pattern = pat_vec_t'({pat_high_reg, pat_low_reg});

    assign chain_d[0] = s_tdata;
    assign chain_v[0] = 1'b1;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        epm_cell #(.IDX(k)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .ctl  (ctl),
            .din  (chain_d[k]),
            .vin  (chain_v[k]),
            .dout (chain_d[k+1]),
            .vout (chain_v[k+1]),
            .eq   (cell_eq[k])
        );
    end

    // occurrence bookkeeping
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [POS_W-1:0] count_reg, count_next;
    logic [POS_W:0]   free_reg, free_next;
    logic             len_ok, hit, report, has_result;
    logic [POS_W-1:0] start, count_inc;
    result_t          res;

    assign len_ok    = (pat_len_reg != '0) && (pat_len_reg <= LEN_W'(NCELL));
    assign hit       = len_ok && (&cell_eq);
    assign start     = pos_reg + POS_W'(1) - POS_W'(pat_len_reg);
    assign report    = hit && (!no_ovlp_reg || ({1'b0, start} >= free_reg));
    assign count_inc = report ? count_reg + POS_W'(1) : count_reg;
    assign has_result = report || s_tlast;

    assign res.found    = report;
    assign res.position = report ? start : '0;
    assign res.done     = s_tlast;
    assign res.count    = count_inc;

    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        free_next  = free_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                pos_next   = '0;
                count_next = '0;
                free_next  = '0;
            end
            else
            begin
                pos_next   = pos_reg + POS_W'(1);
                count_next = count_inc;
                if (report)
                begin
                    free_next = {1'b0, start} + (POS_W+1)'(pat_len_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
            free_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            free_reg  <= free_next;
        end
    end

    // output register plus skid entry
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    push, pop;

    assign s_tready = !skid_valid_reg;
    assign push     = accept && has_result;
    assign pop      = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // input is stalled while the skid entry is full
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.count, out_reg.position};
    assign m_tlast  = out_reg.done;
    assign m_tuser  = out_reg.found;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_no_match_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.found) |-> (out_reg.position == '0))
        else $error("position set on a result without a match");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> ((pos_reg == '0) && (count_reg == '0) && (free_reg == '0)))
        else $error("text state not cleared after last byte");
`endif

endmodule
